>>> rtl/lcpk_pkg.sv
// ----------------------------------------------------------------------------
// lcpk_pkg
// Shared types and constants for the LCP array builder: word layouts,
// memory request bundles and sequencer states.
// ----------------------------------------------------------------------------
package lcpk_pkg;

	localparam int DEPTH  = 4096;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = ADDR_W + 1;
	localparam int SYM_W  = 8;
	localparam int LCP_W  = 12;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SYM_W-1:0]  symbol;
		logic [ADDR_W-1:0] suffix_pos;
		logic              is_last;
		logic [ADDR_W-1:0] rank;
	} in_word_t;

	typedef struct packed {
		logic [LCP_W-1:0]  lcp_value;
		logic [ADDR_W-1:0] out_rank;
		logic              done_res;
	} out_word_t;

	typedef struct packed {
		logic              text_we;
		logic [ADDR_W-1:0] text_waddr;
		logic [SYM_W-1:0]  text_wdata;
		logic [ADDR_W-1:0] text_raddr;
		logic              sfx_we;
		logic [ADDR_W-1:0] sfx_waddr;
		logic [ADDR_W-1:0] sfx_wdata;
		logic [ADDR_W-1:0] sfx_raddr;
		logic              inv_we;
		logic [ADDR_W-1:0] inv_waddr;
		logic [ADDR_W-1:0] inv_wdata;
		logic [ADDR_W-1:0] inv_raddr;
		logic              pfx_we;
		logic [ADDR_W-1:0] pfx_waddr;
		logic [LCP_W-1:0]  pfx_wdata;
		logic [ADDR_W-1:0] pfx_raddr;
	} mem_req_t;

	typedef struct packed {
		logic [SYM_W-1:0]  text;
		logic [ADDR_W-1:0] sfx;
		logic [ADDR_W-1:0] inv;
		logic [LCP_W-1:0]  pfx;
	} mem_rd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_QUERY,
		ST_CLR,
		ST_INV_RD,
		ST_INV_WR,
		ST_W_RANK,
		ST_W_PRED,
		ST_W_J,
		ST_W_A,
		ST_W_B,
		ST_W_C,
		ST_DONE
	} state_t;

endpackage

>>> rtl/lcpk_ram.sv
// ----------------------------------------------------------------------------
// lcpk_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lcpk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/lcpk_unit.sv
// ----------------------------------------------------------------------------
// lcpk_unit
// Shared offset unit: forms base plus match length and checks it against
// the text length, for both symbol fetches and suffix entry range checks.
// ----------------------------------------------------------------------------
module lcpk_unit (
	input  logic [lcpk_pkg::CNT_W-1:0]  base,
	input  logic [lcpk_pkg::CNT_W-1:0]  offs,
	input  logic [lcpk_pkg::CNT_W-1:0]  bound,
	output logic [lcpk_pkg::ADDR_W-1:0] addr,
	output logic                        oob
);

	logic [lcpk_pkg::CNT_W:0] sum;

	assign sum  = {1'b0, base} + {1'b0, offs};
	assign oob  = sum >= {1'b0, bound};
	assign addr = sum[lcpk_pkg::ADDR_W-1:0];

endmodule

>>> rtl/lcpk_seq.sv
// ----------------------------------------------------------------------------
// lcpk_seq
// Sequencer for loads, queries and the three build passes: clear, inverse
// suffix array, and the running-match walk over text positions.
// ----------------------------------------------------------------------------
module lcpk_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  lcpk_pkg::in_word_t  item,
	input  lcpk_pkg::mem_rd_t   rd,
	output lcpk_pkg::mem_req_t  req,
	output logic                idle,
	output logic                res_load,
	output lcpk_pkg::out_word_t res_word
);

	localparam int AW = lcpk_pkg::ADDR_W;
	localparam int CW = lcpk_pkg::CNT_W;

	lcpk_pkg::state_t state_q, state_d;

	logic [CW-1:0]             load_cnt_q;
	logic [CW-1:0]             len_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             l_q;
	logic [AW-1:0]             k_q;
	logic [AW-1:0]             j_q;
	logic [lcpk_pkg::SYM_W-1:0] a_q;
	logic                      a_oob_q;
	logic                      b_oob_q;
	logic [AW-1:0]             rank_q;

	logic [CW-1:0]             u_base;
	logic [CW-1:0]             u_offs;
	logic [AW-1:0]             u_addr;
	logic                      u_oob;

	logic                      cap_full;
	logic [CW-1:0]             load_len;
	logic                      idx_last;
	logic [lcpk_pkg::SYM_W-1:0] b_sym;
	logic                      stop;
	logic [lcpk_pkg::LCP_W-1:0] l_sat;
	logic                      is_load;

	assign cap_full = load_cnt_q >= CW'(lcpk_pkg::DEPTH);
	assign load_len = cap_full ? load_cnt_q : load_cnt_q + CW'(1);
	assign idx_last = (idx_q + CW'(1)) == len_q;
	assign b_sym    = b_oob_q ? '0 : rd.text;
	assign stop     = (a_q != b_sym) || (a_q == '0);
	assign l_sat    = l_q[CW-1] ? '1 : l_q[lcpk_pkg::LCP_W-1:0];
	assign is_load  = accept && (item.kind == lcpk_pkg::KIND_LOAD);

	always_comb begin
		u_base = idx_q;
		u_offs = l_q;
		unique case (state_q)
			lcpk_pkg::ST_INV_WR: begin
				u_base = {1'b0, rd.sfx};
				u_offs = '0;
			end
			lcpk_pkg::ST_W_B: begin
				u_base = {1'b0, j_q};
			end
			default: begin
			end
		endcase
	end

	lcpk_unit u_unit (
		.base  (u_base),
		.offs  (u_offs),
		.bound (len_q),
		.addr  (u_addr),
		.oob   (u_oob)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcpk_pkg::ST_IDLE: begin
				if (accept) begin
					if (item.kind == lcpk_pkg::KIND_QUERY) begin
						state_d = lcpk_pkg::ST_QUERY;
					end else if (item.is_last) begin
						state_d = lcpk_pkg::ST_CLR;
					end
				end
			end
			lcpk_pkg::ST_QUERY: state_d = lcpk_pkg::ST_IDLE;
			lcpk_pkg::ST_CLR: begin
				if (idx_last) state_d = lcpk_pkg::ST_INV_RD;
			end
			lcpk_pkg::ST_INV_RD: state_d = lcpk_pkg::ST_INV_WR;
			lcpk_pkg::ST_INV_WR: begin
				state_d = idx_last ? lcpk_pkg::ST_W_RANK : lcpk_pkg::ST_INV_RD;
			end
			lcpk_pkg::ST_W_RANK: state_d = lcpk_pkg::ST_W_PRED;
			lcpk_pkg::ST_W_PRED: begin
				if (rd.inv == '0) begin
					state_d = idx_last ? lcpk_pkg::ST_DONE : lcpk_pkg::ST_W_RANK;
				end else begin
					state_d = lcpk_pkg::ST_W_J;
				end
			end
			lcpk_pkg::ST_W_J: state_d = lcpk_pkg::ST_W_A;
			lcpk_pkg::ST_W_A: state_d = lcpk_pkg::ST_W_B;
			lcpk_pkg::ST_W_B: state_d = lcpk_pkg::ST_W_C;
			lcpk_pkg::ST_W_C: begin
				if (stop) begin
					state_d = idx_last ? lcpk_pkg::ST_DONE : lcpk_pkg::ST_W_RANK;
				end else begin
					state_d = lcpk_pkg::ST_W_A;
				end
			end
			lcpk_pkg::ST_DONE: state_d = lcpk_pkg::ST_IDLE;
			default: state_d = lcpk_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req       = '0;
		res_load  = 1'b0;
		res_word  = '0;
		idle      = state_q == lcpk_pkg::ST_IDLE;
		unique case (state_q)
			lcpk_pkg::ST_IDLE: begin
				req.pfx_raddr = item.rank;
				if (is_load && !cap_full) begin
					req.text_we    = 1'b1;
					req.text_waddr = load_cnt_q[AW-1:0];
					req.text_wdata = item.symbol;
					req.sfx_we     = 1'b1;
					req.sfx_waddr  = load_cnt_q[AW-1:0];
					req.sfx_wdata  = item.suffix_pos;
				end
			end
			lcpk_pkg::ST_QUERY: begin
				res_load           = 1'b1;
				res_word.lcp_value = rd.pfx;
				res_word.out_rank  = rank_q;
				res_word.done_res  = 1'b0;
			end
			lcpk_pkg::ST_CLR: begin
				req.inv_we    = 1'b1;
				req.inv_waddr = idx_q[AW-1:0];
				req.inv_wdata = '0;
				req.pfx_we    = 1'b1;
				req.pfx_waddr = idx_q[AW-1:0];
				req.pfx_wdata = '0;
			end
			lcpk_pkg::ST_INV_RD: begin
				req.sfx_raddr = idx_q[AW-1:0];
			end
			lcpk_pkg::ST_INV_WR: begin
				req.inv_we    = !u_oob;
				req.inv_waddr = rd.sfx;
				req.inv_wdata = idx_q[AW-1:0];
			end
			lcpk_pkg::ST_W_RANK: begin
				req.inv_raddr = idx_q[AW-1:0];
			end
			lcpk_pkg::ST_W_PRED: begin
				req.sfx_raddr = rd.inv - AW'(1);
				if (rd.inv == '0) begin
					req.pfx_we    = 1'b1;
					req.pfx_waddr = '0;
					req.pfx_wdata = '0;
				end
			end
			lcpk_pkg::ST_W_J: begin
			end
			lcpk_pkg::ST_W_A: begin
				req.text_raddr = u_addr;
			end
			lcpk_pkg::ST_W_B: begin
				req.text_raddr = u_addr;
			end
			lcpk_pkg::ST_W_C: begin
				if (stop) begin
					req.pfx_we    = 1'b1;
					req.pfx_waddr = k_q;
					req.pfx_wdata = l_sat;
				end
			end
			lcpk_pkg::ST_DONE: begin
				res_load          = 1'b1;
				res_word.done_res = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lcpk_pkg::ST_IDLE;
			load_cnt_q <= '0;
			len_q      <= '0;
			idx_q      <= '0;
			l_q        <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lcpk_pkg::ST_IDLE: begin
					if (is_load) begin
						if (!cap_full) load_cnt_q <= load_cnt_q + CW'(1);
						if (item.is_last) begin
							len_q <= load_len;
							idx_q <= '0;
							l_q   <= '0;
						end
					end
				end
				lcpk_pkg::ST_CLR, lcpk_pkg::ST_INV_WR: begin
					idx_q <= idx_last ? '0 : idx_q + CW'(1);
				end
				lcpk_pkg::ST_W_PRED: begin
					if (rd.inv == '0) idx_q <= idx_q + CW'(1);
				end
				lcpk_pkg::ST_W_C: begin
					if (stop) begin
						idx_q <= idx_q + CW'(1);
						if (l_q != '0) l_q <= l_q - CW'(1);
					end else begin
						l_q <= l_q + CW'(1);
					end
				end
				lcpk_pkg::ST_DONE: begin
					load_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			lcpk_pkg::ST_IDLE:   rank_q  <= item.rank;
			lcpk_pkg::ST_W_PRED: k_q     <= rd.inv;
			lcpk_pkg::ST_W_J:    j_q     <= rd.sfx;
			lcpk_pkg::ST_W_A:    a_oob_q <= u_oob;
			lcpk_pkg::ST_W_B: begin
				a_q     <= a_oob_q ? '0 : rd.text;
				b_oob_q <= u_oob;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lcpk_pkg::ST_IDLE && state_q != lcpk_pkg::ST_QUERY &&
		 state_q != lcpk_pkg::ST_DONE) |-> (idx_q < len_q))
		else $error("position index ran past text length");

	a_match_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		l_q <= len_q)
		else $error("match length exceeds text length");

	a_load_cap: assert property (@(posedge clk) disable iff (!arst_n)
		load_cnt_q <= CW'(lcpk_pkg::DEPTH))
		else $error("load count beyond capacity");

	a_done_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lcpk_pkg::ST_DONE) |=>
		(state_q == lcpk_pkg::ST_IDLE && load_cnt_q == '0))
		else $error("build did not return to idle with empty text");
`endif

endmodule

>>> rtl/lcp_array_kasai.sv
// ----------------------------------------------------------------------------
// lcp_array_kasai
// LCP array builder: loads text and suffix array, builds the inverse suffix
// array and runs the running-match walk, then answers rank queries.
// ----------------------------------------------------------------------------
// A plain load word is taken every cycle. A query reads the prefix memory,
// whose read is registered, then loads the result word. The load word marked
// is_last starts the build, during which no word is taken: a clear pass over
// len positions, an inverse pass with a read and a write state per position,
// then the walk, with rank and predecessor states for a position whose rank
// is 0, else rank, predecessor, j, A, B and C states plus A, B and C again
// per matched symbol, the match total being at most 2*len. The two symbols
// of a comparison are fetched in turn through the single read port of the
// text memory and the shared offset unit. The done word follows the walk; a
// word is taken only while the result register is empty or being drained.
// ----------------------------------------------------------------------------
module lcp_array_kasai (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  lcpk_pkg::in_word_t  item,
	output logic                res_valid,
	input  logic                res_stall,
	output lcpk_pkg::out_word_t res
);

	lcpk_pkg::mem_req_t  req;
	lcpk_pkg::mem_rd_t   rd;
	lcpk_pkg::out_word_t res_word;
	logic                idle;
	logic                res_load;
	logic                accept;
	logic                res_valid_q;
	lcpk_pkg::out_word_t res_q;

	assign item_stall = !(idle && (!res_valid_q || !res_stall));
	assign accept     = item_valid && !item_stall;

	lcpk_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.rd       (rd),
		.req      (req),
		.idle     (idle),
		.res_load (res_load),
		.res_word (res_word)
	);

	lcpk_ram #(.WIDTH(lcpk_pkg::SYM_W), .DEPTH(lcpk_pkg::DEPTH)) u_text (
		.clk   (clk),
		.we    (req.text_we),
		.waddr (req.text_waddr),
		.wdata (req.text_wdata),
		.raddr (req.text_raddr),
		.rdata (rd.text)
	);

	lcpk_ram #(.WIDTH(lcpk_pkg::ADDR_W), .DEPTH(lcpk_pkg::DEPTH)) u_sfx (
		.clk   (clk),
		.we    (req.sfx_we),
		.waddr (req.sfx_waddr),
		.wdata (req.sfx_wdata),
		.raddr (req.sfx_raddr),
		.rdata (rd.sfx)
	);

	lcpk_ram #(.WIDTH(lcpk_pkg::ADDR_W), .DEPTH(lcpk_pkg::DEPTH)) u_inv (
		.clk   (clk),
		.we    (req.inv_we),
		.waddr (req.inv_waddr),
		.wdata (req.inv_wdata),
		.raddr (req.inv_raddr),
		.rdata (rd.inv)
	);

	lcpk_ram #(.WIDTH(lcpk_pkg::LCP_W), .DEPTH(lcpk_pkg::DEPTH)) u_pfx (
		.clk   (clk),
		.we    (req.pfx_we),
		.waddr (req.pfx_waddr),
		.wdata (req.pfx_wdata),
		.raddr (req.pfx_raddr),
		.rdata (rd.pfx)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_word;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
